### src/bol_pkg.sv
// Shared types and constants for the bounded ordered list unit.
`default_nettype none

package bol_pkg;

   localparam int DATA_W = 32;
   localparam int KIND_W = 3;
   localparam int STATUS_W = 2;
   localparam int CAPACITY_DEFAULT = 64;

   typedef enum logic [KIND_W-1:0] {
      REQ_INS_HEAD   = 3'd0,
      REQ_INS_TAIL   = 3'd1,
      REQ_INS_AT     = 3'd2,
      REQ_INS_BEFORE = 3'd3,
      REQ_REM_HEAD   = 3'd4,
      REQ_REM_TAIL   = 3'd5,
      REQ_READ_AT    = 3'd6,
      REQ_CLEAR      = 3'd7
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2
   } cell_op_type;

   typedef enum logic {
      QUERY_POSITION = 1'b0,
      QUERY_MATCH    = 1'b1
   } query_type;

   typedef struct packed {
      cell_op_type         op;
      query_type           qkind;
      logic [DATA_W-1:0]   data;
      logic [DATA_W-1:0]   target;
   } cell_ctl_type;

endpackage

`default_nettype wire

### src/bol_cell.sv
// One storage cell of the list chain with its shift and compare logic.
`default_nettype none

module bol_cell #(
   parameter int CAPACITY = bol_pkg::CAPACITY_DEFAULT,
   parameter int CELL_INDEX = 0,
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  wire logic                         clock,
   input  wire bol_pkg::cell_ctl_type        ctl,
   input  wire logic [CNT_W-1:0]             ins_idx,
   input  wire logic [CNT_W-1:0]             key,
   input  wire logic [CNT_W-1:0]             count,
   input  wire logic [bol_pkg::DATA_W-1:0]   prev_value,
   input  wire logic [bol_pkg::DATA_W-1:0]   next_value,
   output logic [bol_pkg::DATA_W-1:0]        value,
   output logic                              hit
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_INDEX);

   logic [bol_pkg::DATA_W-1:0] value_ff;
   logic [bol_pkg::DATA_W-1:0] value_in;
   logic                       match;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         bol_pkg::CELL_INSERT: begin
            if (MY_IDX > ins_idx) begin
               value_in = prev_value;
            end else if (MY_IDX == ins_idx) begin
               value_in = ctl.data;
            end
         end
         bol_pkg::CELL_SHIFT: begin
            value_in = next_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_comb begin
      if (ctl.qkind == bol_pkg::QUERY_MATCH) begin
         match = (value_ff == ctl.target);
      end else begin
         match = (MY_IDX == key);
      end
      hit = (MY_IDX < count) && match;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

### src/bol_tree.sv
// Registered priority tree that finds the lowest cell with its hit flag set.
`default_nettype none

module bol_tree #(
   parameter int CAPACITY = bol_pkg::CAPACITY_DEFAULT,
   localparam int LEVELS = $clog2(CAPACITY),
   localparam int LEAVES = 1 << LEVELS,
   localparam int IDX_W = LEVELS
) (
   input  wire logic                         clock,
   input  wire logic [CAPACITY-1:0]          leaf_hit,
   input  wire logic [bol_pkg::DATA_W-1:0]   leaf_value [CAPACITY],
   output logic                              root_hit,
   output logic [IDX_W-1:0]                  root_idx,
   output logic [bol_pkg::DATA_W-1:0]        root_value
);

   typedef struct packed {
      logic                       hit;
      logic [IDX_W-1:0]           idx;
      logic [bol_pkg::DATA_W-1:0] value;
   } node_type;

   node_type node [2*LEAVES-1];
   node_type node_ff [LEAVES-1];

   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < CAPACITY) begin : g_used
         assign node[LEAVES-1+j] = '{hit: leaf_hit[j], idx: IDX_W'(j), value: leaf_value[j]};
      end else begin : g_pad
         assign node[LEAVES-1+j] = '{hit: 1'b0, idx: IDX_W'(j), value: '0};
      end
   end

   // The left child always covers the lower indexes, so it wins a tie.
   for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
      always_ff @(posedge clock) begin
         node_ff[k] <= node[2*k+1].hit ? node[2*k+1] : node[2*k+2];
      end
      assign node[k] = node_ff[k];
   end

   assign root_hit = node[0].hit;
   assign root_idx = node[0].idx;
   assign root_value = node[0].value;

endmodule

`default_nettype wire

### src/bounded_ordered_list_unit.sv
// Top level of the bounded ordered list unit: request sequencer, cell chain and search tree.
// A request passes through the search, update and tail states before its response is registered.
// One request is in work at a time; the next is taken once the last response is registered.
// The registered search tree is passed twice, once before the update and once for a tail lookup
// after it. The response register lets the next request in while one waits.
// Reset clears the element count and the handshake state; cell contents are left as they are.
`default_nettype none

module bounded_ordered_list_unit #(
   parameter int CAPACITY = bol_pkg::CAPACITY_DEFAULT,
   localparam int CNT_W = $clog2(CAPACITY + 1),
   localparam int REQ_TDATA_W = ((2 * bol_pkg::DATA_W + CNT_W + 7) / 8) * 8,
   localparam int RSP_TDATA_W = ((3 * bol_pkg::DATA_W + CNT_W + 1 + 7) / 8) * 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // data_value, target_value, position, zero fill
   input  wire logic [REQ_TDATA_W-1:0]     req_tdata,
   // req_type
   input  wire logic [bol_pkg::KIND_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // read_value, element_count, head_value, tail_value, list_empty, zero fill
   output logic [RSP_TDATA_W-1:0]          rsp_tdata,
   // status, read_valid
   output logic [2:0]                      rsp_tuser
);

   localparam int DATA_W = bol_pkg::DATA_W;
   localparam int LEVELS = $clog2(CAPACITY);
   localparam int IDX_W = LEVELS;
   localparam int WAIT_W = $clog2(LEVELS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);
   localparam int RSP_USED_W = 3 * DATA_W + CNT_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_TAIL   = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [WAIT_W-1:0]         wait_ff, wait_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   bol_pkg::cell_op_type      op_ff, op_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   bol_pkg::req_kind_type     kind_ff, kind_in;
   logic [DATA_W-1:0]         data_ff, data_in;
   logic [DATA_W-1:0]         target_ff, target_in;
   logic [CNT_W-1:0]          pos_ff, pos_in;
   bol_pkg::query_type        qkind_ff, qkind_in;
   logic [CNT_W-1:0]          key_ff, key_in;
   logic [CNT_W-1:0]          ins_idx_ff, ins_idx_in;
   bol_pkg::status_type       status_ff, status_in;
   logic [DATA_W-1:0]         rval_ff, rval_in;
   logic                      rvalid_ff, rvalid_in;

   bol_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]         rsp_rval_ff, rsp_rval_in;
   logic                      rsp_rvalid_ff, rsp_rvalid_in;
   logic [CNT_W-1:0]          rsp_count_ff, rsp_count_in;
   logic [DATA_W-1:0]         rsp_head_ff, rsp_head_in;
   logic [DATA_W-1:0]         rsp_tail_ff, rsp_tail_in;
   logic                      rsp_empty_ff, rsp_empty_in;

   bol_pkg::cell_ctl_type     cell_ctl;
   logic [DATA_W-1:0]         cell_value [CAPACITY];
   logic [CAPACITY-1:0]       cell_hit;
   logic                      root_hit;
   logic [IDX_W-1:0]          root_idx;
   logic [DATA_W-1:0]         root_value;
   logic [CNT_W-1:0]          next_count;
   logic [RSP_USED_W-1:0]     rsp_fields;

   assign cell_ctl = '{op: op_ff, qkind: qkind_ff, data: data_ff, target: target_ff};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int PREV = (i == 0) ? 0 : i - 1;
      localparam int NEXT = (i == CAPACITY - 1) ? i : i + 1;
      bol_cell #(
         .CAPACITY   (CAPACITY),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .ins_idx    (ins_idx_ff),
         .key        (key_ff),
         .count      (count_ff),
         .prev_value (cell_value[PREV]),
         .next_value (cell_value[NEXT]),
         .value      (cell_value[i]),
         .hit        (cell_hit[i])
      );
   end

   bol_tree #(
      .CAPACITY (CAPACITY)
   ) u_tree (
      .clock      (clock),
      .leaf_hit   (cell_hit),
      .leaf_value (cell_value),
      .root_hit   (root_hit),
      .root_idx   (root_idx),
      .root_value (root_value)
   );

   always_comb begin
      state_in = state_ff;
      wait_in = wait_ff;
      count_in = count_ff;
      op_in = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      kind_in = kind_ff;
      data_in = data_ff;
      target_in = target_ff;
      pos_in = pos_ff;
      qkind_in = qkind_ff;
      key_in = key_ff;
      ins_idx_in = ins_idx_ff;
      status_in = status_ff;
      rval_in = rval_ff;
      rvalid_in = rvalid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rval_in = rsp_rval_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_head_in = rsp_head_ff;
      rsp_tail_in = rsp_tail_ff;
      rsp_empty_in = rsp_empty_ff;
      next_count = count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in = bol_pkg::req_kind_type'(req_tuser);
               data_in = req_tdata[DATA_W-1:0];
               target_in = req_tdata[2*DATA_W-1:DATA_W];
               pos_in = req_tdata[2*DATA_W +: CNT_W];
               if (bol_pkg::req_kind_type'(req_tuser) == bol_pkg::REQ_INS_BEFORE) begin
                  qkind_in = bol_pkg::QUERY_MATCH;
               end else begin
                  qkind_in = bol_pkg::QUERY_POSITION;
               end
               key_in = req_tdata[2*DATA_W +: CNT_W];
               wait_in = WAIT_W'(LEVELS);
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - WAIT_W'(1);
            end else begin
               status_in = bol_pkg::STATUS_OK;
               rval_in = '0;
               rvalid_in = 1'b0;
               op_in = bol_pkg::CELL_HOLD;
               ins_idx_in = '0;
               if ((kind_ff == bol_pkg::REQ_INS_HEAD || kind_ff == bol_pkg::REQ_INS_TAIL ||
                    kind_ff == bol_pkg::REQ_INS_AT || kind_ff == bol_pkg::REQ_INS_BEFORE) &&
                   count_ff == FULL_COUNT) begin
                  status_in = bol_pkg::STATUS_FULL;
               end else begin
                  case (kind_ff)
                     bol_pkg::REQ_INS_HEAD: begin
                        op_in = bol_pkg::CELL_INSERT;
                        next_count = count_ff + CNT_W'(1);
                     end
                     bol_pkg::REQ_INS_TAIL: begin
                        op_in = bol_pkg::CELL_INSERT;
                        ins_idx_in = count_ff;
                        next_count = count_ff + CNT_W'(1);
                     end
                     bol_pkg::REQ_INS_AT: begin
                        op_in = bol_pkg::CELL_INSERT;
                        ins_idx_in = (pos_ff < count_ff) ? pos_ff : count_ff;
                        next_count = count_ff + CNT_W'(1);
                     end
                     bol_pkg::REQ_INS_BEFORE: begin
                        if (count_ff == '0) begin
                           op_in = bol_pkg::CELL_INSERT;
                           next_count = count_ff + CNT_W'(1);
                        end else if (root_hit) begin
                           op_in = bol_pkg::CELL_INSERT;
                           ins_idx_in = CNT_W'(root_idx);
                           next_count = count_ff + CNT_W'(1);
                        end else begin
                           status_in = bol_pkg::STATUS_NOT_FOUND;
                        end
                     end
                     bol_pkg::REQ_REM_HEAD: begin
                        if (count_ff == '0) begin
                           status_in = bol_pkg::STATUS_EMPTY;
                        end else begin
                           op_in = bol_pkg::CELL_SHIFT;
                           next_count = count_ff - CNT_W'(1);
                        end
                     end
                     bol_pkg::REQ_REM_TAIL: begin
                        if (count_ff == '0) begin
                           status_in = bol_pkg::STATUS_EMPTY;
                        end else begin
                           next_count = count_ff - CNT_W'(1);
                        end
                     end
                     bol_pkg::REQ_READ_AT: begin
                        if (count_ff == '0) begin
                           status_in = bol_pkg::STATUS_EMPTY;
                        end else if (root_hit) begin
                           rval_in = root_value;
                           rvalid_in = 1'b1;
                        end
                     end
                     bol_pkg::REQ_CLEAR: begin
                        next_count = '0;
                     end
                     default: begin
                        next_count = count_ff;
                     end
                  endcase
               end
               count_in = next_count;
               qkind_in = bol_pkg::QUERY_POSITION;
               key_in = next_count - CNT_W'(1);
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            op_in = bol_pkg::CELL_HOLD;
            wait_in = WAIT_W'(LEVELS);
            state_in = ST_TAIL;
         end
         ST_TAIL: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - WAIT_W'(1);
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_rval_in = rval_ff;
               rsp_rvalid_in = rvalid_ff;
               rsp_count_in = count_ff;
               rsp_head_in = (count_ff != '0) ? cell_value[0] : '0;
               rsp_tail_in = root_hit ? root_value : '0;
               rsp_empty_in = (count_ff == '0);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff <= '0;
         count_ff <= '0;
         op_ff <= bol_pkg::CELL_HOLD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
         count_ff <= count_in;
         op_ff <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      data_ff <= data_in;
      target_ff <= target_in;
      pos_ff <= pos_in;
      qkind_ff <= qkind_in;
      key_ff <= key_in;
      ins_idx_ff <= ins_idx_in;
      status_ff <= status_in;
      rval_ff <= rval_in;
      rvalid_ff <= rvalid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rval_ff <= rsp_rval_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_count_ff <= rsp_count_in;
      rsp_head_ff <= rsp_head_in;
      rsp_tail_ff <= rsp_tail_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = {rsp_rvalid_ff, rsp_status_ff};
   assign rsp_fields = {rsp_empty_ff, rsp_tail_ff, rsp_head_ff, rsp_count_ff, rsp_rval_ff};
   assign rsp_tdata = RSP_TDATA_W'(rsp_fields);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("element count exceeds capacity");

   a_accept_starts_search: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_SEARCH)
      else $error("accepted request did not start a search");

   a_update_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |=> op_ff == bol_pkg::CELL_HOLD)
      else $error("cell operation held past the update cycle");

   a_insert_index: assert property (@(posedge clock) disable iff (reset)
      op_ff == bol_pkg::CELL_INSERT |-> (count_ff != '0 && ins_idx_ff < count_ff))
      else $error("insert index outside the grown list");

   a_ops_only_in_update: assert property (@(posedge clock) disable iff (reset)
      op_ff != bol_pkg::CELL_HOLD |-> state_ff == ST_UPDATE)
      else $error("cell operation outside the update cycle");

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bounded ordered list unit, with a queue-based list predictor.
module testbench;
   import bol_pkg::*;

   localparam int CAPACITY = CAPACITY_DEFAULT;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int REQ_TDATA_W = ((2 * DATA_W + CNT_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((3 * DATA_W + CNT_W + 1 + 7) / 8) * 8;
   localparam int COUNT_LO = DATA_W;
   localparam int HEAD_LO = COUNT_LO + CNT_W;
   localparam int TAIL_LO = HEAD_LO + DATA_W;
   localparam int EMPTY_BIT = TAIL_LO + DATA_W;
   localparam int LATENCY = 2 * $clog2(CAPACITY) + 3;
   localparam int RANDOM_PER_PHASE = 425;
   localparam int BIAS_SPAN = 120;

   localparam logic [DATA_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] ABSENT_VALUE = 32'hDEAD_BEEF;

   typedef struct packed {
      status_type        status;
      logic              read_valid;
      logic [DATA_W-1:0] read_value;
      logic [CNT_W-1:0]  element_count;
      logic [DATA_W-1:0] head_value;
      logic [DATA_W-1:0] tail_value;
      logic              list_empty;
   } list_result_type;

   typedef struct packed {
      req_kind_type      kind;
      logic [DATA_W-1:0] data_value;
      logic [DATA_W-1:0] target_value;
      logic [CNT_W-1:0]  position;
      logic [7:0]        repeats;
      logic              has_want;
      list_result_type   want;
   } directed_row_type;

   localparam list_result_type NO_RESULT = '0;
   localparam list_result_type EMPTY_REJECT = '{STATUS_EMPTY, 1'b0, 32'h0, 7'd0, 32'h0, 32'h0,
                                               1'b1};
   localparam list_result_type CLEARED = '{STATUS_OK, 1'b0, 32'h0, 7'd0, 32'h0, 32'h0, 1'b1};
   localparam list_result_type FULL_REJECT = '{STATUS_FULL, 1'b0, 32'h0, 7'd64, 32'h100,
                                              32'h13F, 1'b0};

   localparam directed_row_type DIRECTED_ROWS [26] = '{
      '{REQ_REM_HEAD,   32'h0,         32'h0,         7'd0,   8'd1,  1'b1, EMPTY_REJECT},
      '{REQ_REM_TAIL,   32'h0,         32'h0,         7'd0,   8'd1,  1'b1, EMPTY_REJECT},
      '{REQ_READ_AT,    32'h0,         32'h0,         7'd0,   8'd1,  1'b1, EMPTY_REJECT},
      '{REQ_READ_AT,    ALL_ONES,      ALL_ONES,      7'd127, 8'd1,  1'b1, EMPTY_REJECT},
      '{REQ_INS_BEFORE, MOST_POSITIVE, 32'h5,         7'd0,   8'd1,  1'b1,
        '{STATUS_OK, 1'b0, 32'h0, 7'd1, MOST_POSITIVE, MOST_POSITIVE, 1'b0}},
      '{REQ_INS_HEAD,   MOST_NEGATIVE, 32'h0,         7'd0,   8'd1,  1'b1,
        '{STATUS_OK, 1'b0, 32'h0, 7'd2, MOST_NEGATIVE, MOST_POSITIVE, 1'b0}},
      '{REQ_INS_TAIL,   ALL_ONES,      32'h0,         7'd0,   8'd1,  1'b1,
        '{STATUS_OK, 1'b0, 32'h0, 7'd3, MOST_NEGATIVE, ALL_ONES, 1'b0}},
      '{REQ_INS_AT,     32'h0,         32'h0,         7'd127, 8'd1,  1'b1,
        '{STATUS_OK, 1'b0, 32'h0, 7'd4, MOST_NEGATIVE, 32'h0, 1'b0}},
      '{REQ_INS_AT,     32'h5555_5555, 32'h0,         7'd1,   8'd1,  1'b0, NO_RESULT},
      '{REQ_INS_BEFORE, 32'hAAAA_AAAA, 32'h5555_5555, 7'd0,   8'd1,  1'b0, NO_RESULT},
      '{REQ_INS_BEFORE, 32'h1,         MOST_NEGATIVE, 7'd0,   8'd1,  1'b0, NO_RESULT},
      '{REQ_INS_BEFORE, 32'h2,         32'h0,         7'd0,   8'd1,  1'b0, NO_RESULT},
      '{REQ_INS_BEFORE, 32'h3,         ABSENT_VALUE,  7'd0,   8'd1,  1'b0, NO_RESULT},
      '{REQ_READ_AT,    32'h0,         32'h0,         7'd0,   8'd1,  1'b0, NO_RESULT},
      '{REQ_READ_AT,    32'h0,         32'h0,         7'd7,   8'd1,  1'b0, NO_RESULT},
      '{REQ_READ_AT,    32'h0,         32'h0,         7'd8,   8'd1,  1'b0, NO_RESULT},
      '{REQ_REM_HEAD,   32'h0,         32'h0,         7'd0,   8'd1,  1'b0, NO_RESULT},
      '{REQ_REM_TAIL,   32'h0,         32'h0,         7'd0,   8'd1,  1'b0, NO_RESULT},
      '{REQ_CLEAR,      32'h0,         32'h0,         7'd0,   8'd1,  1'b1, CLEARED},
      '{REQ_INS_TAIL,   32'h100,       32'h0,         7'd0,   8'd65, 1'b0, NO_RESULT},
      '{REQ_INS_HEAD,   32'h5,         32'h0,         7'd0,   8'd1,  1'b1, FULL_REJECT},
      '{REQ_INS_BEFORE, 32'h6,         ABSENT_VALUE,  7'd0,   8'd1,  1'b1, FULL_REJECT},
      '{REQ_INS_AT,     32'h7,         32'h0,         7'd3,   8'd1,  1'b1, FULL_REJECT},
      '{REQ_READ_AT,    32'h0,         32'h0,         7'd63,  8'd1,  1'b0, NO_RESULT},
      '{REQ_READ_AT,    32'h0,         32'h0,         7'd64,  8'd1,  1'b0, NO_RESULT},
      '{REQ_CLEAR,      32'h0,         32'h0,         7'd0,   8'd1,  1'b1, CLEARED}
   };

   localparam int SENDER_IDLE [4] = '{0, 64, 0, 19};
   localparam int RECEIVER_STALL [4] = '{0, 0, 64, 19};
   localparam int INSERT_BIAS [4] = '{10, 45, 70, 95};

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [2:0]             rsp_tuser;

   logic [DATA_W-1:0] list_contents[$];
   list_result_type   expected_results[$];
   list_result_type   observed;
   list_result_type   oldest;
   int                mismatch_count = 0;
   int                sender_idle_pct = 0;
   int                receiver_stall_pct = 0;

   bounded_ordered_list_unit #(.CAPACITY(CAPACITY)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   function automatic list_result_type apply_request(input req_kind_type kind,
                                                     input logic [DATA_W-1:0] dval,
                                                     input logic [DATA_W-1:0] tval,
                                                     input logic [CNT_W-1:0] pos);
      list_result_type res;
      int              idx;
      res = NO_RESULT;
      res.status = STATUS_OK;
      if (kind <= REQ_INS_BEFORE && list_contents.size() >= CAPACITY) begin
         res.status = STATUS_FULL;
      end else begin
         case (kind)
            REQ_INS_HEAD: list_contents.push_front(dval);
            REQ_INS_TAIL: list_contents.push_back(dval);
            REQ_INS_AT: begin
               idx = (int'(pos) < list_contents.size()) ? int'(pos) : list_contents.size();
               list_contents.insert(idx, dval);
            end
            REQ_INS_BEFORE: begin
               idx = 0;
               while (idx < list_contents.size() && list_contents[idx] != tval) idx++;
               if (list_contents.size() == 0) begin
                  list_contents.push_front(dval);
               end else if (idx < list_contents.size()) begin
                  list_contents.insert(idx, dval);
               end else begin
                  res.status = STATUS_NOT_FOUND;
               end
            end
            REQ_REM_HEAD: begin
               if (list_contents.size() == 0) res.status = STATUS_EMPTY;
               else void'(list_contents.pop_front());
            end
            REQ_REM_TAIL: begin
               if (list_contents.size() == 0) res.status = STATUS_EMPTY;
               else void'(list_contents.pop_back());
            end
            REQ_READ_AT: begin
               if (list_contents.size() == 0) begin
                  res.status = STATUS_EMPTY;
               end else if (int'(pos) < list_contents.size()) begin
                  res.read_value = list_contents[pos];
                  res.read_valid = 1'b1;
               end
            end
            default: list_contents.delete();
         endcase
      end
      res.element_count = CNT_W'(list_contents.size());
      res.list_empty = (list_contents.size() == 0);
      if (list_contents.size() != 0) begin
         res.head_value = list_contents[0];
         res.tail_value = list_contents[list_contents.size() - 1];
      end
      return res;
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(3))
               0: return MOST_NEGATIVE;
               1: return MOST_POSITIVE;
               2: return ALL_ONES;
               default: return '0;
            endcase
         end
         1, 2, 3: return $urandom;
         default: return $urandom_range(15);
      endcase
   endfunction

   task automatic send_request(input req_kind_type kind, input logic [DATA_W-1:0] dval,
                               input logic [DATA_W-1:0] tval, input logic [CNT_W-1:0] pos,
                               input logic has_want, input list_result_type want);
      list_result_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {{(REQ_TDATA_W - 2 * DATA_W - CNT_W){1'b0}}, pos, tval, dval};
      do @(posedge clock); while (!req_tready);
      predicted = apply_request(kind, dval, tval, pos);
      expected_results.push_back(has_want ? want : predicted);
      @(negedge clock);
   endtask

   task automatic send_random_request(input int insert_pct);
      req_kind_type      kind;
      logic [DATA_W-1:0] tval;
      logic [CNT_W-1:0]  pos;
      int                roll;
      roll = $urandom_range(99);
      if (roll < 2) begin
         kind = REQ_CLEAR;
      end else if (roll < 2 + insert_pct) begin
         kind = req_kind_type'($urandom_range(REQ_INS_BEFORE, REQ_INS_HEAD));
      end else begin
         kind = req_kind_type'($urandom_range(REQ_READ_AT, REQ_REM_HEAD));
      end
      // Most searches aim at a value that is in the list so that matches land everywhere.
      if (list_contents.size() != 0 && $urandom_range(9) < 7) begin
         tval = list_contents[$urandom_range(list_contents.size() - 1)];
      end else begin
         tval = pick_value();
      end
      case ($urandom_range(3))
         0: pos = CNT_W'($urandom_range(2 ** CNT_W - 1));
         1: pos = CNT_W'($urandom_range(CAPACITY));
         default: pos = CNT_W'($urandom_range(list_contents.size()));
      endcase
      send_request(kind, pick_value(), tval, pos, 1'b0, NO_RESULT);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed.status = status_type'(rsp_tuser[1:0]);
         observed.read_valid = rsp_tuser[2];
         observed.read_value = rsp_tdata[DATA_W-1:0];
         observed.element_count = rsp_tdata[COUNT_LO +: CNT_W];
         observed.head_value = rsp_tdata[HEAD_LO +: DATA_W];
         observed.tail_value = rsp_tdata[TAIL_LO +: DATA_W];
         observed.list_empty = rsp_tdata[EMPTY_BIT];
         if (expected_results.size() == 0) begin
            $display("%0t: unrequested response, expected none, actual %h", $time, observed);
            mismatch_count++;
         end else begin
            oldest = expected_results.pop_front();
            check_field("status", oldest.status, observed.status);
            check_field("read_valid", oldest.read_valid, observed.read_valid);
            check_field("read_value", oldest.read_value, observed.read_value);
            check_field("element_count", oldest.element_count, observed.element_count);
            check_field("head_value", oldest.head_value, observed.head_value);
            check_field("tail_value", oldest.tail_value, observed.tail_value);
            check_field("list_empty", oldest.list_empty, observed.list_empty);
         end
      end
   end

   initial begin
      int insert_pct;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_INS_HEAD;
      insert_pct = INSERT_BIAS[0];
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r]) begin
         for (int n = 0; n < DIRECTED_ROWS[r].repeats; n++) begin
            send_request(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].data_value + n,
                         DIRECTED_ROWS[r].target_value, DIRECTED_ROWS[r].position,
                         DIRECTED_ROWS[r].has_want, DIRECTED_ROWS[r].want);
         end
      end
      wait_for_results();

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = SENDER_IDLE[phase];
         receiver_stall_pct = RECEIVER_STALL[phase];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n % BIAS_SPAN == 0) insert_pct = INSERT_BIAS[$urandom_range(3)];
            send_random_request(insert_pct);
         end
         // The sender holds off here until every request has been answered.
         wait_for_results();
      end

      repeat (4 * LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

### bounded_ordered_list_unit.f
src/bol_pkg.sv
src/bol_cell.sv
src/bol_tree.sv
src/bounded_ordered_list_unit.sv
tb/testbench.sv
